### rtl/core/polyline_step_resampler_unit_defines.svh
// Assertion macros for the checker file of this block.
`ifndef POLYLINE_STEP_RESAMPLER_UNIT_DEFINES_SVH
`define POLYLINE_STEP_RESAMPLER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pslr_pkg.sv
package pslr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MAX_STEPS   = 63;
    localparam int STEP_WIDTH  = 16;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(256);

    // n never exceeds MAX_STEPS; the search candidate may reach MAX_STEPS + 1.
    localparam int N_W    = $clog2(MAX_STEPS + 1);
    localparam int CNT_W  = $clog2(MAX_STEPS + 2);
    localparam int LEN_W  = STEP_WIDTH + CNT_W;
    localparam int MUL_W  = (LEN_W > COORD_WIDTH) ? LEN_W : COORD_WIDTH;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIST_W = 2 * COORD_WIDTH + 1;
    localparam int DCNT_W = $clog2(COORD_WIDTH);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0]        mag_t;
    typedef logic [STEP_WIDTH-1:0]         step_t;
    typedef logic [N_W-1:0]                nstep_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_SEARCH,
        ST_DIVX,
        ST_DIVY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [MUL_W-1:0] mul_a;
        logic [MUL_W-1:0] mul_b;
        nstep_t           div_rem;
        logic             div_bit;
        nstep_t           divisor;
    } arith_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        nstep_t            rem;
        logic              qbit;
    } arith_rsp_t;

endpackage

### rtl/core/polyline_step_resampler_unit.sv
// Resamples a polyline at a fixed largest spacing. A vertex with path_start set (or the
// first vertex after reset) is stored. Any other vertex closes a segment of n steps
// (1 <= n <= 63) and emits n + 1 points, end points included, one per cycle while
// out_ready is high; it keeps the input closed through the squared length, the
// step-count search, the division of |dx| and |dy| by n, and the output. The work is
// done by the single shared multiplier and divide-step unit, which does one squaring or
// one quotient bit per cycle. step_length may only be written while the block is idle.
module polyline_step_resampler_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pslr_pkg::step_t     cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  pslr_pkg::coord_t    vertex_x,
    input  pslr_pkg::coord_t    vertex_y,
    input  logic                path_start,
    output logic                out_valid,
    input  logic                out_ready,
    output pslr_pkg::coord_t    out_x,
    output pslr_pkg::coord_t    out_y,
    output logic                last_of_run,
    output logic                step_clipped
);
    import pslr_pkg::*;

    localparam int CW = COORD_WIDTH;

    arith_req_t req;
    arith_rsp_t rsp;

    // Control state, set by reset.
    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic              have_prev_reg, have_prev_next;
    coord_t            prev_x_reg, prev_x_next;
    coord_t            prev_y_reg, prev_y_next;
    logic              pv_reg, pv_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers.
    coord_t            base_x_reg, base_x_next;
    coord_t            base_y_reg, base_y_next;
    mag_t              mag_x_reg, mag_x_next;
    mag_t              mag_y_reg, mag_y_next;
    logic              neg_x_reg, neg_x_next;
    logic              neg_y_reg, neg_y_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic [CNT_W-1:0]  pc_reg, pc_next;
    nstep_t            n_reg, n_next;
    logic              clip_reg, clip_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    nstep_t            rem_reg, rem_next;
    mag_t              dvd_reg, dvd_next;
    mag_t              qs_x_reg, qs_x_next;
    mag_t              qs_y_reg, qs_y_next;
    nstep_t            rs_x_reg, rs_x_next;
    nstep_t            rs_y_reg, rs_y_next;
    nstep_t            i_reg, i_next;
    mag_t              qa_x_reg, qa_x_next;
    mag_t              qa_y_reg, qa_y_next;
    nstep_t            ra_x_reg, ra_x_next;
    nstep_t            ra_y_reg, ra_y_next;
    coord_t            out_x_reg, out_x_next;
    coord_t            out_y_reg, out_y_next;
    logic              last_reg, last_next;
    logic              oclip_reg, oclip_next;

    logic [CW:0]       dx_in, dy_in;
    logic [CW:0]       abs_x, abs_y;
    logic [N_W:0]      sum_rx, sum_ry;
    mag_t              quo_shift;

    pslr_arith u_arith (
        .req (req),
        .rsp (rsp)
    );

    always_comb
    begin
        dx_in = {vertex_x[CW-1], vertex_x} - {prev_x_reg[CW-1], prev_x_reg};
        dy_in = {vertex_y[CW-1], vertex_y} - {prev_y_reg[CW-1], prev_y_reg};
        abs_x = dx_in[CW] ? (~dx_in + 1'b1) : dx_in;
        abs_y = dy_in[CW] ? (~dy_in + 1'b1) : dy_in;
        sum_rx = {1'b0, ra_x_reg} + {1'b0, rs_x_reg};
        sum_ry = {1'b0, ra_y_reg} + {1'b0, rs_y_reg};
        quo_shift = {dvd_reg[CW-2:0], rsp.qbit};

        req.mul_a   = (state_reg == ST_SQX) ? MUL_W'(mag_x_reg) :
                      (state_reg == ST_SQY) ? MUL_W'(mag_y_reg) : MUL_W'(len_reg);
        req.mul_b   = req.mul_a;
        req.div_rem = rem_reg;
        req.div_bit = dvd_reg[CW-1];
        req.divisor = n_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        pv_next        = pv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        len_next       = len_reg;
        mcnt_next      = mcnt_reg;
        pc_next        = pc_reg;
        n_next         = n_reg;
        clip_next      = clip_reg;
        dcnt_next      = dcnt_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        qs_x_next      = qs_x_reg;
        qs_y_next      = qs_y_reg;
        rs_x_next      = rs_x_reg;
        rs_y_next      = rs_y_reg;
        i_next         = i_reg;
        qa_x_next      = qa_x_reg;
        qa_y_next      = qa_y_reg;
        ra_x_next      = ra_x_reg;
        ra_y_next      = ra_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        last_next      = last_reg;
        oclip_next     = oclip_reg;
        in_ready       = 1'b0;

        if (cfg_valid)
        begin
            step_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    prev_x_next    = vertex_x;
                    prev_y_next    = vertex_y;
                    have_prev_next = 1'b1;
                    if (!path_start && have_prev_reg)
                    begin
                        base_x_next = prev_x_reg;
                        base_y_next = prev_y_reg;
                        mag_x_next  = abs_x[CW-1:0];
                        mag_y_next  = abs_y[CW-1:0];
                        neg_x_next  = dx_in[CW];
                        neg_y_next  = dy_in[CW];
                        state_next  = ST_SQX;
                    end
                end
            end
            ST_SQX:
            begin
                prod_next  = rsp.prod;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                dist_next  = prod_reg[DIST_W-1:0];
                prod_next  = rsp.prod;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                dist_next  = dist_reg + prod_reg[DIST_W-1:0];
                len_next   = LEN_W'(step_reg);
                mcnt_next  = CNT_W'(1);
                pv_next    = 1'b0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                // The square of candidate pc is compared in the cycle after it is formed,
                // while the next candidate is already being squared.
                prod_next = rsp.prod;
                pc_next   = mcnt_reg;
                len_next  = len_reg + LEN_W'(step_reg);
                mcnt_next = mcnt_reg + 1'b1;
                pv_next   = 1'b1;
                if (pv_reg)
                begin
                    if (prod_reg > PROD_W'(dist_reg))
                    begin
                        n_next     = pc_reg[N_W-1:0];
                        clip_next  = 1'b0;
                        dcnt_next  = '0;
                        rem_next   = '0;
                        dvd_next   = mag_x_reg;
                        state_next = ST_DIVX;
                    end
                    else if (pc_reg == CNT_W'(MAX_STEPS))
                    begin
                        n_next     = N_W'(MAX_STEPS);
                        clip_next  = 1'b1;
                        dcnt_next  = '0;
                        rem_next   = '0;
                        dvd_next   = mag_x_reg;
                        state_next = ST_DIVX;
                    end
                end
            end
            ST_DIVX:
            begin
                rem_next  = rsp.rem;
                dvd_next  = quo_shift;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(CW - 1))
                begin
                    qs_x_next  = quo_shift;
                    rs_x_next  = rsp.rem;
                    rem_next   = '0;
                    dvd_next   = mag_y_reg;
                    dcnt_next  = '0;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                rem_next  = rsp.rem;
                dvd_next  = quo_shift;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(CW - 1))
                begin
                    qs_y_next  = quo_shift;
                    rs_y_next  = rsp.rem;
                    i_next     = '0;
                    qa_x_next  = '0;
                    qa_y_next  = '0;
                    ra_x_next  = '0;
                    ra_y_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next = base_x_reg + (neg_x_reg ? (~qa_x_reg + 1'b1) : qa_x_reg);
                    out_y_next = base_y_reg + (neg_y_reg ? (~qa_y_reg + 1'b1) : qa_y_reg);
                    last_next  = (i_reg == n_reg);
                    oclip_next = clip_reg;
                    if (i_reg == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // i*|d|/n kept as quotient and remainder, stepped by |d|/n.
                        i_next = i_reg + 1'b1;
                        if (sum_rx >= {1'b0, n_reg})
                        begin
                            ra_x_next = N_W'(sum_rx - {1'b0, n_reg});
                            qa_x_next = qa_x_reg + qs_x_reg + 1'b1;
                        end
                        else
                        begin
                            ra_x_next = sum_rx[N_W-1:0];
                            qa_x_next = qa_x_reg + qs_x_reg;
                        end
                        if (sum_ry >= {1'b0, n_reg})
                        begin
                            ra_y_next = N_W'(sum_ry - {1'b0, n_reg});
                            qa_y_next = qa_y_reg + qs_y_reg + 1'b1;
                        end
                        else
                        begin
                            ra_y_next = sum_ry[N_W-1:0];
                            qa_y_next = qa_y_reg + qs_y_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        prod_reg   <= prod_next;
        dist_reg   <= dist_next;
        len_reg    <= len_next;
        mcnt_reg   <= mcnt_next;
        pc_reg     <= pc_next;
        n_reg      <= n_next;
        clip_reg   <= clip_next;
        dcnt_reg   <= dcnt_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        qs_x_reg   <= qs_x_next;
        qs_y_reg   <= qs_y_next;
        rs_x_reg   <= rs_x_next;
        rs_y_reg   <= rs_y_next;
        i_reg      <= i_next;
        qa_x_reg   <= qa_x_next;
        qa_y_reg   <= qa_y_next;
        ra_x_reg   <= ra_x_next;
        ra_y_reg   <= ra_y_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        last_reg   <= last_next;
        oclip_reg  <= oclip_next;
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign last_of_run  = last_reg;
    assign step_clipped = oclip_reg;

endmodule

### rtl/core/pslr_arith.sv
module pslr_arith (
    input  pslr_pkg::arith_req_t req,
    output pslr_pkg::arith_rsp_t rsp
);
    import pslr_pkg::*;

    logic [N_W:0] trial;
    logic [N_W:0] diff;
    logic         qbit;

    // One multiplier and one restoring divide step, shared by the squaring, search and division phases.
    always_comb
    begin
        trial    = {req.div_rem, req.div_bit};
        diff     = trial - {1'b0, req.divisor};
        qbit     = (trial >= {1'b0, req.divisor});
        rsp.prod = PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
        rsp.qbit = qbit;
        rsp.rem  = qbit ? diff[N_W-1:0] : trial[N_W-1:0];
    end

endmodule

### rtl/core/pslr_checker.sv
`include "polyline_step_resampler_unit_defines.svh"

module pslr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             path_start,
    input logic             out_valid,
    input logic             out_ready,
    input pslr_pkg::coord_t out_x,
    input pslr_pkg::coord_t out_y,
    input logic             last_of_run,
    input logic             step_clipped
);
    import pslr_pkg::*;

    // A stalled result item keeps its payload.
    `PSLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(last_of_run) && $stable(step_clipped), "stalled output item changed")

    // While a run is still being emitted the input stays closed.
    `PSLR_ASSERT_SAME(a_busy_in_run, out_valid && !last_of_run, !in_ready, "input open in the middle of a run")

    // A path start vertex produces no item.
    `PSLR_ASSERT_NEXT(a_start_silent, in_valid && in_ready && path_start && !out_valid, !out_valid, "output after a path start vertex")

    // The clip flag is the same on every point of a run.
    `PSLR_ASSERT_NEXT(a_clip_steady, out_valid && out_ready && !last_of_run, !out_valid || (step_clipped == $past(step_clipped)), "clip flag changed within a run")

endmodule

bind polyline_step_resampler_unit pslr_checker u_pslr_checker (.*);
